/* src/assert_macros.svh */
// Assertion macros shared by the power squelch modules.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define PSQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/psq_pkg.sv */
// Types and constants for the power squelch with hang timer.
// No dependencies; used by every module of the block.
package psq_pkg;

  localparam int FRAC_W    = 16;
  localparam int THRESH_W  = 32;
  localparam int HOLD_W    = 16;
  localparam int LEVEL_W   = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DW    = 32;
  localparam int OUT_TW    = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKED    = 8'd3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd1074;
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd100;

  typedef enum logic [1:0] {
    GATE_CLOSED = 2'd0,
    GATE_OPEN   = 2'd1,
    GATE_HOLD   = 2'd2
  } gate_t;

  typedef struct packed {
    logic load;
    logic square;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic update;
    logic gate;
  } psq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } psq_stat_t;

endpackage

/* src/psq_ctrl.sv */
// Sequencing controller for the power squelch datapath.
// Depends on psq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psq_pkg::psq_stat_t  stat,
  output psq_pkg::psq_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQR, S_DIFF, S_MLO, S_MHI, S_SUM, S_UPD, S_GATE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.square = (state == S_SQR);
    cmd.diff   = (state == S_DIFF);
    cmd.mul_lo = (state == S_MLO);
    cmd.mul_hi = (state == S_MHI);
    cmd.sum    = (state == S_SUM);
    cmd.update = (state == S_UPD);
    cmd.gate   = (state == S_GATE) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_SQR;
        S_SQR:  state <= S_DIFF;
        S_DIFF: state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_SUM;
        S_SUM:  state <= S_UPD;
        S_UPD:  state <= S_GATE;
        S_GATE: if (!stat.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSQ_ASSERT_SAME(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `PSQ_ASSERT_NEXT(a_load_then_square, clk, rst, cmd.load, cmd.square)

endmodule

/* src/psq_dp.sv */
// Datapath: squaring, one-pole energy average, threshold gate and result register.
// Depends on psq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psq_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int ALPHA_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  psq_pkg::psq_cmd_t                    cmd,
  output psq_pkg::psq_stat_t                   stat,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_q,
  input  logic [ALPHA_BITS-1:0]                alpha,
  input  logic [psq_pkg::THRESH_W-1:0]         threshold_energy,
  input  logic [psq_pkg::HOLD_W-1:0]           hold_samples,
  input  logic                                 locked,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [1:0]                           squelch_status,
  output logic                                 muted,
  output logic [psq_pkg::LEVEL_W-1:0]          energy_level
);

  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int EW     = SQ_W + psq_pkg::FRAC_W;
  localparam int HALF   = EW / 2;
  localparam int PW     = ALPHA_BITS + EW;
  localparam int TW_EXT = psq_pkg::THRESH_W + psq_pkg::FRAC_W;
  localparam int CW     = (EW > TW_EXT) ? EW : TW_EXT;

  logic signed [SAMPLE_BITS-1:0]      i_r;
  logic signed [SAMPLE_BITS-1:0]      q_r;
  logic signed [SQ_W-1:0]             prod_i;
  logic signed [SQ_W-1:0]             prod_q;
  logic [SQ_W-1:0]                    sq_i;
  logic [SQ_W-1:0]                    sq_q;
  logic [EW-1:0]                      x_val;
  logic [EW-1:0]                      diff;
  logic                               up;
  logic [ALPHA_BITS+HALF-1:0]         p_lo;
  logic [ALPHA_BITS+EW-HALF-1:0]      p_hi;
  logic [PW-1:0]                      step;
  logic [EW-1:0]                      quot;
  logic                               rem;
  logic [EW-1:0]                      energy;
  logic [EW-1:0]                      energy_int;
  logic                               above;
  psq_pkg::gate_t                     gate;
  psq_pkg::gate_t                     gate_next;
  logic [psq_pkg::HOLD_W-1:0]         hold_count;
  logic [psq_pkg::HOLD_W-1:0]         hold_count_next;
  logic [psq_pkg::HOLD_W-1:0]         hold_dec;

  assign prod_i = i_r * i_r;
  assign prod_q = q_r * q_r;
  assign x_val  = (EW'(sq_i) + EW'(sq_q)) << psq_pkg::FRAC_W;
  assign step   = (PW'(p_hi) << HALF) + PW'(p_lo);
  assign above  = CW'(energy) > CW'({threshold_energy, {psq_pkg::FRAC_W{1'b0}}});
  assign hold_dec = (hold_count != '0) ? hold_count - 1'b1 : hold_count;
  assign energy_int = energy >> psq_pkg::FRAC_W;

  always_comb begin
    gate_next       = gate;
    hold_count_next = hold_count;
    if (!locked) begin
      if (above) begin
        gate_next = psq_pkg::GATE_OPEN;
      end else begin
        case (gate)
          psq_pkg::GATE_OPEN: begin
            gate_next       = psq_pkg::GATE_HOLD;
            hold_count_next = hold_samples;
          end
          psq_pkg::GATE_HOLD: begin
            hold_count_next = hold_dec;
            if (hold_dec == '0) gate_next = psq_pkg::GATE_CLOSED;
          end
          default: gate_next = psq_pkg::GATE_CLOSED;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_r <= sample_i;
      q_r <= sample_q;
    end
    if (cmd.square) begin
      sq_i <= $unsigned(prod_i);
      sq_q <= $unsigned(prod_q);
    end
    if (cmd.diff) begin
      up   <= (x_val >= energy);
      diff <= (x_val >= energy) ? x_val - energy : energy - x_val;
    end
    if (cmd.mul_lo) begin
      p_lo <= (ALPHA_BITS+HALF)'(alpha) * (ALPHA_BITS+HALF)'(diff[HALF-1:0]);
    end
    if (cmd.mul_hi) begin
      p_hi <= (ALPHA_BITS+EW-HALF)'(alpha) * (ALPHA_BITS+EW-HALF)'(diff[EW-1:HALF]);
    end
    if (cmd.sum) begin
      quot <= step[PW-1:ALPHA_BITS];
      rem  <= (step[ALPHA_BITS-1:0] != '0);
    end
    if (cmd.gate) begin
      squelch_status <= gate_next;
      muted          <= (gate_next == psq_pkg::GATE_CLOSED);
      energy_level   <= psq_pkg::LEVEL_W'(energy_int);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy     <= '0;
      gate       <= psq_pkg::GATE_CLOSED;
      hold_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.update) begin
        energy <= up ? energy + quot : energy - quot - EW'(rem);
      end
      if (cmd.gate) begin
        gate       <= gate_next;
        hold_count <= hold_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  `PSQ_ASSERT_NEXT(a_locked_freezes_gate, clk, rst, cmd.gate && locked, $stable(gate))
  `PSQ_ASSERT_NEXT(a_rise_not_below, clk, rst, cmd.update && up, energy >= $past(energy))
  `PSQ_ASSERT_SAME(a_muted_matches_status, clk, rst, out_valid,
                   muted == (squelch_status == psq_pkg::GATE_CLOSED))

endmodule

/* src/power_squelch_with_hang_timer.sv */
// Power squelch with hang timer: the controller steps one sample at a time through
// squaring, difference, two halves of the alpha multiplier, sum, average update and
// gate decision, and takes no new input beat until the gate step of the last is done.
// A full output register stalls the gate step until the beat is taken.
// Synchronous reset clears the average, gate, hold counter and restores the registers.
module power_squelch_with_hang_timer #(
  parameter int SAMPLE_BITS = 16,
  parameter int ALPHA_BITS  = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // Fields from bit 0: sample_i, sample_q, zero fill.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // Fields from bit 0: squelch_status[1:0], muted, energy_level[31:0], zero fill.
  output logic [psq_pkg::OUT_TW-1:0]                m_tdata,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [psq_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [psq_pkg::CFG_DW-1:0]                cfg_data
);

  logic [ALPHA_BITS-1:0]              alpha;
  logic [psq_pkg::THRESH_W-1:0]       threshold_energy;
  logic [psq_pkg::HOLD_W-1:0]         hold_samples;
  logic                               locked;
  psq_pkg::psq_cmd_t                  cmd;
  psq_pkg::psq_stat_t                 stat;
  logic [1:0]                         squelch_status;
  logic                               muted;
  logic [psq_pkg::LEVEL_W-1:0]        energy_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha            <= ALPHA_BITS'(6554);
      threshold_energy <= psq_pkg::THRESH_RESET;
      hold_samples     <= psq_pkg::HOLD_RESET;
      locked           <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psq_pkg::CFG_ALPHA:     alpha            <= cfg_data[ALPHA_BITS-1:0];
        psq_pkg::CFG_THRESHOLD: threshold_energy <= cfg_data[psq_pkg::THRESH_W-1:0];
        psq_pkg::CFG_HOLD:      hold_samples     <= cfg_data[psq_pkg::HOLD_W-1:0];
        psq_pkg::CFG_LOCKED:    locked           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  psq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psq_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ALPHA_BITS  (ALPHA_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .sample_i         ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .sample_q         ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .alpha            (alpha),
    .threshold_energy (threshold_energy),
    .hold_samples     (hold_samples),
    .locked           (locked),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .squelch_status   (squelch_status),
    .muted            (muted),
    .energy_level     (energy_level)
  );

  assign m_tdata = {5'b0, energy_level, muted, squelch_status};

endmodule

/* verif/tb_power_squelch_with_hang_timer.sv */
// Self-checking testbench for power_squelch_with_hang_timer: streams I/Q sample beats,
// predicts gate status and smoothed energy per beat and checks every output beat.
// Depends on psq_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_power_squelch_with_hang_timer;

  localparam int IDLE_LIMIT = 2000;
  localparam int SQUEEZE_AT = 520;
  localparam int SQUEEZE_CYCLES = 300;
  localparam logic [psq_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

  typedef struct packed {
    psq_pkg::gate_t              status;
    logic                        muted;
    logic [psq_pkg::LEVEL_W-1:0] level;
  } squelch_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [psq_pkg::OUT_TW-1:0]    m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [psq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [psq_pkg::CFG_DW-1:0]    cfg_data = '0;

  logic tx_gaps = 1'b1;
  logic rx_gaps = 1'b1;

  // Predictor state and its copy of the registers.
  logic [15:0]                alpha_m = 16'd6554;
  logic [31:0]                thresh_m = psq_pkg::THRESH_RESET;
  logic [psq_pkg::HOLD_W-1:0] hold_m = psq_pkg::HOLD_RESET;
  logic                       lock_m = 1'b0;
  logic [63:0]                energy_m = '0;
  psq_pkg::gate_t             gate_m = psq_pkg::GATE_CLOSED;
  logic [psq_pkg::HOLD_W-1:0] hold_cnt_m = '0;

  logic [31:0]     sample_backlog[$];
  squelch_result_t expected_results[$];

  int samples_queued = 0;
  int results_seen;
  int errors = 0;
  int tx_wait;
  int rx_wait;
  int squeeze_left;
  int stall_cycles = 0;

  power_squelch_with_hang_timer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic squelch_result_t advance_squelch(input logic [31:0] beat);
    longint          si;
    longint          sq;
    logic [63:0]     target;
    logic [63:0]     diff;
    logic [79:0]     prod;
    squelch_result_t r;
    si = longint'($signed(beat[15:0]));
    sq = longint'($signed(beat[31:16]));
    target = 64'(si * si + sq * sq) << psq_pkg::FRAC_W;
    if (target >= energy_m) begin
      diff = target - energy_m;
      prod = {16'd0, diff} * {64'd0, alpha_m};
      energy_m = energy_m + prod[79:16];
    end else begin
      diff = energy_m - target;
      prod = {16'd0, diff} * {64'd0, alpha_m};
      energy_m = energy_m - (prod[79:16] + (prod[15:0] != 16'd0));
    end
    if (!lock_m) begin
      if (energy_m > ({32'd0, thresh_m} << psq_pkg::FRAC_W)) begin
        gate_m = psq_pkg::GATE_OPEN;
      end else if (gate_m == psq_pkg::GATE_OPEN) begin
        gate_m = psq_pkg::GATE_HOLD;
        hold_cnt_m = hold_m;
      end else if (gate_m == psq_pkg::GATE_HOLD) begin
        if (hold_cnt_m != 0) hold_cnt_m = hold_cnt_m - 1'b1;
        if (hold_cnt_m == 0) gate_m = psq_pkg::GATE_CLOSED;
      end else begin
        gate_m = psq_pkg::GATE_CLOSED;
      end
    end
    r.status = gate_m;
    r.muted = (gate_m == psq_pkg::GATE_CLOSED);
    r.level = energy_m[47:16];
    return r;
  endfunction

  function automatic void apply_reg(input logic [psq_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [psq_pkg::CFG_DW-1:0] val);
    case (idx)
      psq_pkg::CFG_ALPHA:     alpha_m = val[15:0];
      psq_pkg::CFG_THRESHOLD: thresh_m = val;
      psq_pkg::CFG_HOLD:      hold_m = val[psq_pkg::HOLD_W-1:0];
      psq_pkg::CFG_LOCKED:    lock_m = val[0];
      default: ;
    endcase
  endfunction

  function automatic int rand_component(input int lvl);
    return int'($urandom_range(0, 2 * lvl)) - lvl;
  endfunction

  task automatic queue_sample(input int i_val, input int q_val);
    sample_backlog.push_back({q_val[15:0], i_val[15:0]});
    samples_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen < samples_queued);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psq_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Bursts of loud signal, silence, low-level noise and lone full-scale samples.
  task automatic queue_bursts(input int count, input int amp);
    int kind;
    int len;
    int lvl;
    int left;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len = (kind == 9) ? 1 : $urandom_range(1, 30);
      if (len > left) len = left;
      lvl = (kind < 5) ? amp : (kind == 8) ? amp / 8 : 0;
      repeat (len) begin
        if (kind == 9) begin
          queue_sample($urandom_range(0, 1) ? -32768 : 32767,
                       $urandom_range(0, 1) ? -32768 : 32767);
        end else begin
          queue_sample(rand_component(lvl), rand_component(lvl));
        end
      end
      left -= len;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(advance_squelch(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          s_tvalid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          s_tdata <= sample_backlog.pop_front();
          s_tvalid <= 1'b1;
          tx_wait <= tx_gaps ? $urandom_range(0, 18) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    squelch_result_t want;
    int              gap;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
      squeeze_left <= 0;
      results_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] != want.status) begin
            $display("%0t: squelch_status expected %0d actual %0d",
                     $time, want.status, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[2] != want.muted) begin
            $display("%0t: muted expected %0d actual %0d", $time, want.muted, m_tdata[2]);
            errors++;
          end
          if (m_tdata[34:3] != want.level) begin
            $display("%0t: energy_level expected %0d actual %0d",
                     $time, want.level, m_tdata[34:3]);
            errors++;
          end
        end
      end
      if (squeeze_left != 0) begin
        squeeze_left <= squeeze_left - 1;
        m_tready <= (squeeze_left == 1);
      end else if (m_tvalid && m_tready && results_seen + 1 == SQUEEZE_AT) begin
        squeeze_left <= SQUEEZE_CYCLES;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        gap = rx_gaps ? $urandom_range(0, 18) : 0;
        rx_wait <= gap;
        m_tready <= (gap == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_tready <= (rx_wait == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int amp;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Full-scale corners, zero and unit samples with the reset settings.
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(0, 0);
    queue_sample(1, -1);
    queue_sample(-1, 1);
    wait_drained();

    // Fastest average, lowest threshold and shortest hold: open, hold, close.
    write_reg(psq_pkg::CFG_ALPHA, 32'd65535);
    write_reg(psq_pkg::CFG_THRESHOLD, 32'd0);
    write_reg(psq_pkg::CFG_HOLD, 32'd1);
    queue_sample(32767, 0);
    repeat (5) queue_sample(0, 0);
    queue_sample(-32768, -32768);
    wait_drained();

    // Alpha and hold both zero after masking wide writes; an unused index is ignored.
    write_reg(psq_pkg::CFG_ALPHA, 32'hABCD_0000);
    write_reg(psq_pkg::CFG_HOLD, 32'h5A5A_0000);
    write_reg(psq_pkg::CFG_THRESHOLD, 32'h8000_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_sample(100, -100);
    queue_sample(0, 0);
    queue_sample(0, 0);
    wait_drained();

    // Locked gate while the slowest average still moves.
    write_reg(psq_pkg::CFG_ALPHA, 32'd1);
    write_reg(psq_pkg::CFG_THRESHOLD, 32'd0);
    write_reg(psq_pkg::CFG_LOCKED, 32'h0000_0003);
    queue_sample(32767, -32768);
    queue_sample(12345, -23456);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      amp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 32767);
      write_reg(psq_pkg::CFG_ALPHA,
                ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535)
                                            : $urandom_range(1024, 65535));
      write_reg(psq_pkg::CFG_THRESHOLD,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h8000_0000)
                                            : $urandom_range(amp * amp / 16, amp * amp));
      write_reg(psq_pkg::CFG_HOLD,
                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                            : $urandom_range(1, 24));
      write_reg(psq_pkg::CFG_LOCKED, ($urandom_range(0, 5) == 0));
      tx_gaps <= ($urandom_range(0, 3) != 0);
      rx_gaps <= ($urandom_range(0, 3) != 0);
      queue_bursts(140, amp);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
